// ===== src/sss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants and types for the sample set statistics block.
// ----------------------------------------------------------------------------
package sss_pkg;
  localparam int MAX_SAMPLES_DEF = 32;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int SD_W     = 16;
  localparam int COUNT_W  = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MODE_RD,
    ST_MODE_CMP,
    ST_MATH,
    ST_OUT
  } sss_state_t;

  // math unit sequencer
  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_DIV1,
    M_SQRT,
    M_DIV2,
    M_FIN
  } sss_math_state_t;

  // math unit handshake
  typedef struct packed {
    logic start;
    logic done;
  } sss_math_ctl_t;
endpackage

// ===== src/sss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/sss_math.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_math
// Sequential mean divide, variance square root and standard deviation divide.
// ----------------------------------------------------------------------------
module sss_math import sss_pkg::*; #(
  parameter int SUM_W = 22,
  parameter int SQ_W  = 36,
  parameter int N_W   = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  sum,
  input  logic [SQ_W-1:0]          sum_sq,
  input  logic [N_W-1:0]           n,
  output logic                     done,
  output logic signed [MEAN_W-1:0] mean_q8,
  output logic [SD_W-1:0]          std_dev
);
  localparam int SC_W = SUM_W + 8;                    // magnitude of sum*256
  localparam int D_W  = 2 * ((SQ_W + N_W + 1) / 2);   // n*sum_sq, whole bit pairs
  localparam int R_W  = D_W / 2;
  localparam int CW   = $clog2(D_W + 2);

  sss_math_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0] diff_r, diff_nxt;
  logic [SC_W-1:0] quo_r, quo_nxt;
  logic [SC_W-1:0] rem_r, rem_nxt;
  logic [R_W-1:0] root_r, root_nxt;
  logic [R_W+1:0] srem_r, srem_nxt;
  logic neg_r, neg_nxt;
  logic [SUM_W-1:0] abs_w;
  logic [SC_W-1:0] rem_sh;
  logic [R_W+1:0] s_trial;
  logic signed [SC_W:0] mean_w;

  assign abs_w = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign rem_sh = {rem_r[SC_W-2:0], quo_r[SC_W-1]};
  assign s_trial = {srem_r[R_W-1:0], diff_r[D_W-1 -: 2]} - {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt; diff_r <= diff_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    root_r <= root_nxt; srem_r <= srem_nxt; neg_r <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; diff_nxt = diff_r; quo_nxt = quo_r;
    rem_nxt = rem_r; root_nxt = root_r; srem_nxt = srem_r; neg_nxt = neg_r;
    done = 1'b0;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          neg_nxt = sum[SUM_W-1];
          quo_nxt = {abs_w, 8'd0};
          rem_nxt = '0;
          // n*sum_sq needs one narrow multiply; register it
          diff_nxt = D_W'(n) * D_W'(sum_sq);
          cnt_nxt = CW'(SC_W);
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        diff_nxt = diff_r - D_W'(D_W'(abs_w) * D_W'(abs_w));
        state_nxt = M_DIV1;
      end
      M_DIV1: begin
        // restoring divide of |sum|*256 by n, one bit a cycle
        if (rem_sh >= SC_W'(n)) begin
          rem_nxt = rem_sh - SC_W'(n);
          quo_nxt = {quo_r[SC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[SC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          root_nxt = '0; srem_nxt = '0;
          cnt_nxt = CW'(R_W);
          state_nxt = M_SQRT;
        end
      end
      M_SQRT: begin
        // two bits of the radicand a cycle
        if (!s_trial[R_W+1]) begin
          srem_nxt = s_trial;
          root_nxt = {root_r[R_W-2:0], 1'b1};
        end else begin
          srem_nxt = {srem_r[R_W-1:0], diff_r[D_W-1 -: 2]};
          root_nxt = {root_r[R_W-2:0], 1'b0};
        end
        diff_nxt = {diff_r[D_W-3:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          cnt_nxt = CW'(R_W);
          state_nxt = M_DIV2;
        end
      end
      M_DIV2: begin
        // reuse diff_r low bits as root quotient, srem as remainder
        if (cnt_r == CW'(R_W) && srem_r != '1) begin
          srem_nxt = '1; // marker: load phase
          diff_nxt = D_W'(root_r);
          rem_nxt = rem_r;
        end else begin
          if ({srem_r[R_W:0], diff_r[R_W-1]} >= (R_W+2)'(n)) begin
            srem_nxt = {srem_r[R_W:0], diff_r[R_W-1]} - (R_W+2)'(n);
            diff_nxt = {diff_r[D_W-1:R_W], diff_r[R_W-2:0], 1'b1};
          end else begin
            srem_nxt = {srem_r[R_W:0], diff_r[R_W-1]};
            diff_nxt = {diff_r[D_W-1:R_W], diff_r[R_W-2:0], 1'b0};
          end
          if (srem_r == '1) begin
            srem_nxt = '0; // first real bit uses cleared remainder
            if (diff_r[R_W-1] >= 1'b1 && n == N_W'(1)) begin
              diff_nxt = {diff_r[D_W-1:R_W], diff_r[R_W-2:0], 1'b1};
            end else begin
              srem_nxt = (R_W+2)'(diff_r[R_W-1]);
              diff_nxt = {diff_r[D_W-1:R_W], diff_r[R_W-2:0], 1'b0};
            end
          end
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = M_FIN;
          end
        end
      end
      M_FIN: begin
        done = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  // floor for negative: -(q) - (rem != 0)
  assign mean_w = neg_r ? -$signed({1'b0, quo_r}) - (SC_W+1)'(rem_r != '0)
                        : $signed({1'b0, quo_r});
  assign mean_q8 = MEAN_W'(mean_w);
  assign std_dev = SD_W'(diff_r[R_W-1:0]);
endmodule

// ===== src/sample_set_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_set_statistics
// Mean, mode and population standard deviation of a set of signed samples.
// ----------------------------------------------------------------------------
// channel  dir  ports                                          beat
// in       in   in_valid/in_ready, in_sample, in_last          one sample
// out      out  out_valid/out_ready, out_mean_q8, out_mode_value,
//               out_std_dev, out_count                         one result
//
// A stored sample beat j (0-based) is accepted, and then, before the next
// accept, the mode count walks the j+1 stored entries through the single
// RAM read port, one read state and one compare state each. A dropped beat
// starts no walk. The closing beat then runs the math unit: start
// and multiply, 30 mean divide steps, 22 root steps, 23 root divide
// steps and a done cycle. Reset clears counters and sums; the sample RAM is
// never cleared, since only entries of the current set are read. The result
// register holds while out_ready is low; in_ready is low from closing beat
// to delivery.
// ----------------------------------------------------------------------------
module sample_set_statistics import sss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] out_mean_q8,
  output logic signed [SAMPLE_W-1:0] out_mode_value,
  output logic [SD_W-1:0]          out_std_dev,
  output logic [COUNT_W-1:0]       out_count
);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + N_W;
  localparam int SQ_W  = 2 * SAMPLE_W + N_W;

  sss_state_t state_r, state_nxt;
  logic [N_W-1:0] fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic signed [SAMPLE_W-1:0] cur_r, cur_nxt;     // sample under count
  logic [N_W-1:0] idx_r, idx_nxt;                 // walk index
  logic [N_W-1:0] freq_r, freq_nxt, best_r, best_nxt;
  logic signed [SAMPLE_W-1:0] mode_r, mode_nxt;
  logic last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] rdata;
  logic we;
  logic [AW-1:0] raddr;
  logic [N_W-1:0] freq_inc;
  logic math_done;
  logic signed [MEAN_W-1:0] mean_w;
  logic [SD_W-1:0] sd_w;
  sss_math_ctl_t mctl;
  logic signed [SAMPLE_W-1:0] sq_a;

  assign in_ready = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign we = in_valid && in_ready && (fill_r < N_W'(MAX_SAMPLES));
  assign raddr = idx_r[AW-1:0];
  assign sq_a = in_sample;
  assign mctl.start = (state_r == ST_MATH) && !last_r;
  assign mctl.done = math_done;
  assign freq_inc = freq_r + N_W'(rdata == cur_r);

  sss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk(clk), .we(we), .waddr(fill_r[AW-1:0]), .wdata(in_sample),
    .raddr(raddr), .rdata(rdata)
  );

  sss_math #(.SUM_W(SUM_W), .SQ_W(SQ_W), .N_W(N_W)) u_math (
    .clk(clk), .rst_n(rst_n), .start(mctl.start), .sum(sum_r), .sum_sq(sq_r),
    .n(fill_r), .done(math_done), .mean_q8(mean_w), .std_dev(sd_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r <= '0; sum_r <= '0; sq_r <= '0; best_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt; sum_r <= sum_nxt; sq_r <= sq_nxt; best_r <= best_nxt;
    end
    cur_r <= cur_nxt; idx_r <= idx_nxt; freq_r <= freq_nxt;
    mode_r <= mode_nxt; last_r <= last_nxt;
    if (mctl.done) begin
      out_mean_q8 <= mean_w;
      out_std_dev <= sd_w;
    end
  end

  assign out_mode_value = mode_r;
  assign out_count = COUNT_W'(fill_r);

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; sum_nxt = sum_r; sq_nxt = sq_r;
    cur_nxt = cur_r; idx_nxt = idx_r; freq_nxt = freq_r; best_nxt = best_r;
    mode_nxt = mode_r; last_nxt = last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (we) begin
            fill_nxt = fill_r + 1'b1;
            sum_nxt = sum_r + SUM_W'(in_sample);
            sq_nxt = sq_r + SQ_W'($unsigned(32'(sq_a * sq_a)));
            // count matches of the new sample over the stored set
            cur_nxt = in_sample;
            idx_nxt = '0;
            freq_nxt = '0;
            state_nxt = ST_MODE_RD;
          end else if (in_last) begin
            last_nxt = 1'b0;
            state_nxt = ST_MATH;
          end
        end
      end
      ST_MODE_RD: begin
        state_nxt = ST_MODE_CMP;
      end
      ST_MODE_CMP: begin
        freq_nxt = freq_inc;
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == fill_r) begin
          if (freq_inc >= best_r) begin
            best_nxt = freq_inc;
            mode_nxt = cur_r;
          end
          if (last_r) begin
            last_nxt = 1'b0;
            state_nxt = ST_MATH;
          end else begin
            state_nxt = ST_LOAD;
          end
        end else begin
          state_nxt = ST_MODE_RD;
        end
      end
      ST_MATH: begin
        last_nxt = 1'b1; // start pulses one cycle
        if (mctl.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          fill_nxt = '0; sum_nxt = '0; sq_nxt = '0; best_nxt = '0;
          last_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

// ===== dv/sss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_checker
// Watches the sample and result channels of sample_set_statistics, predicts
// the statistics of each closed set and compares every result beat.
// ----------------------------------------------------------------------------
module sss_checker import sss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [MEAN_W-1:0]    out_mean_q8,
  input  logic signed [SAMPLE_W-1:0]  out_mode_value,
  input  logic [SD_W-1:0]             out_std_dev,
  input  logic [COUNT_W-1:0]          out_count,
  output int                          fail_count,
  output int                          pending,
  output int                          sets_seen,
  output int                          full_sets
);

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean_q8;
    logic signed [SAMPLE_W-1:0] mode_value;
    logic [SD_W-1:0]            std_dev;
    logic [COUNT_W-1:0]         count;
  } set_stats_t;

  logic signed [SAMPLE_W-1:0] held_samples[MAX_SAMPLES];
  int                         held_n;
  longint                     sum_acc;
  longint unsigned            sq_acc;
  set_stats_t                 stats_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic set_stats_t close_set();
    set_stats_t      r;
    longint          scaled, mean;
    longint unsigned abs_sum, diff;
    int              best_freq, best_idx, freq;
    scaled = sum_acc * 256;
    mean = scaled / held_n;
    if (scaled % held_n != 0 && scaled < 0) mean -= 1;
    abs_sum = (sum_acc < 0) ? -sum_acc : sum_acc;
    diff = longint'(held_n) * sq_acc - abs_sum * abs_sum;
    best_freq = 0;
    best_idx = 0;
    // latest last occurrence wins ties: >= keeps moving forward
    for (int j = 0; j < held_n; j++) begin
      freq = 0;
      for (int i = 0; i <= j; i++)
        if (held_samples[i] == held_samples[j]) freq++;
      if (freq >= best_freq) begin
        best_freq = freq;
        best_idx = j;
      end
    end
    r.mean_q8 = mean[MEAN_W-1:0];
    r.mode_value = held_samples[best_idx];
    r.std_dev = SD_W'(int_sqrt(diff) / held_n);
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  assign pending = stats_q.size();

  always @(posedge clk) begin
    set_stats_t e;
    if (!rst_n) begin
      held_n = 0;
      sum_acc = 0;
      sq_acc = 0;
      fail_count <= 0;
      sets_seen <= 0;
      full_sets <= 0;
      stats_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("%0t unexpected result beat", $time);
        end else begin
          e = stats_q.pop_front();
          if (e.mean_q8 !== out_mean_q8 || e.mode_value !== out_mode_value ||
              e.std_dev !== out_std_dev || e.count !== out_count) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("%0t mismatch exp mean=%0d mode=%0d sd=%0d n=%0d got %0d %0d %0d %0d",
                       $time, e.mean_q8, e.mode_value, e.std_dev, e.count,
                       out_mean_q8, out_mode_value, out_std_dev, out_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        // blocking on the set state so a closing beat sees its own sample
        if (held_n < MAX_SAMPLES) begin
          held_samples[held_n] = in_sample;
          held_n = held_n + 1;
          sum_acc = sum_acc + in_sample;
          sq_acc = sq_acc + longint'(in_sample) * longint'(in_sample);
        end
        if (in_last) begin
          if (held_n == MAX_SAMPLES) full_sets <= full_sets + 1;
          stats_q.push_back(close_set());
          sets_seen <= sets_seen + 1;
          held_n = 0;
          sum_acc = 0;
          sq_acc = 0;
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for sample_set_statistics: directed sets, then random
// sets of mixed size under bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb;
  import sss_pkg::*;

  localparam int NSAMP = MAX_SAMPLES_DEF;

  logic clk, rst_n;
  logic in_valid, in_ready, in_last;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid, out_ready;
  logic signed [MEAN_W-1:0] out_mean_q8;
  logic signed [SAMPLE_W-1:0] out_mode_value;
  logic [SD_W-1:0] out_std_dev;
  logic [COUNT_W-1:0] out_count;
  int fail_count, pending, sets_seen, full_sets;
  int beats_sent;
  bit long_hold;   // ask the receiver for one long stall
  bit stall_en;
  bit drained;     // set once the sender has waited for every result

  sample_set_statistics #(.MAX_SAMPLES(NSAMP)) dut (.*);

  sss_checker #(.MAX_SAMPLES(NSAMP)) chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, stretches with none, and one long hold-off
  // counted here in cycles.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
        out_ready <= 1;
      end else if (!stall_en) begin
        out_ready <= 1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offer one beat and hold it until accepted.
  task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic l);
    in_valid <= 1;
    in_sample <= s;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid, then idle for a random gap now and then.
  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample(int kind);
    case (kind)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return SAMPLE_W'($urandom_range(0, 7) - 4);  // small pool, mode ties
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_set(int n, int kind);
    for (int i = 0; i < n; i++) begin
      send_beat(rand_sample(kind == 4 ? $urandom_range(0, 3) : kind), i == n - 1);
      if (stall_en) idle_gap();
    end
  endtask

  initial begin
    int n, kind;
    rst_n = 0;
    in_valid = 0;
    in_sample = 0;
    in_last = 0;
    long_hold = 0;
    stall_en = 0;
    drained = 0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: single samples at the extremes, ties, and a full set plus
    // overflow samples (the last of which is ignored but still closes).
    send_beat(16'h8000, 1);
    send_beat(16'h7fff, 1);
    send_beat(16'h0000, 1);
    send_beat(16'hffff, 0); send_beat(16'h0001, 0); send_beat(16'h0001, 0);
    send_beat(16'hffff, 1);
    send_beat(16'h8000, 0); send_beat(16'h7fff, 1);
    send_set(NSAMP, 0);
    send_set(NSAMP + 3, 1);
    in_valid <= 0;

    // Random part under pressure: one long receiver hold while sending.
    stall_en = 1;
    long_hold = 1;
    while (beats_sent < 1600) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(NSAMP - 1, NSAMP + 4)
                                       : $urandom_range(1, 8);
      kind = $urandom_range(0, 9) < 3 ? 2 : ($urandom_range(0, 9) == 0 ? 4 : 3);
      send_set(n, kind);
      if ($urandom_range(0, 60) == 0 || (!drained && beats_sent > 800)) begin
        // pause until every result has come home
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        drained = 1;
      end
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("tb: %0d sample beats, %0d sets closed, %0d sets filled to capacity",
             beats_sent, sets_seen, full_sets);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sample_set_statistics.f =====
src/sss_pkg.sv
src/sss_ram.sv
src/sss_math.sv
src/sample_set_statistics.sv
dv/sss_checker.sv
dv/tb.sv
